// ----- src/bsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants for the bezier smoothing control point pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // default coordinate format, unsigned Q10.4
    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int COORD_INT_BITS_DEF  = 10;

    // smoothness factor, unsigned Q0.16
    localparam int          SMOOTH_W     = 16;
    localparam logic [15:0] SMOOTH_RESET = 16'd49152;

    // length ratio, unsigned Q1.16 in 0..1.0 inclusive
    localparam int          RATIO_W = 17;
    localparam logic [16:0] Q16_ONE = 17'h10000;

    // product scale: offset = d * w * s / 2^33
    localparam int OFFSET_SHIFT = 33;

    // result format, signed 16 bit
    localparam int          OUT_W   = 16;
    localparam int          OUT_MAX = 32767;
    localparam int          OUT_MIN = -32768;
    localparam logic [15:0] OUT_POS = 16'h7fff;
    localparam logic [15:0] OUT_NEG = 16'h8000;

endpackage

// ----- src/bsc_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module bsc_isqrt #(
    parameter int RW = 15
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] rad,
    output logic [RW-1:0]   root
);

    logic [2*RW-1:0] rad_reg  [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];

    genvar i;
    generate
        for (i = 0; i < RW; i++)
        begin : g_step
            logic [2*RW-1:0] rad_p;
            logic [RW+1:0]   rem_p;
            logic [RW-1:0]   root_p;
            logic [RW+3:0]   rem_sh;
            logic [RW+3:0]   trial;
            logic            ge;
            logic [2*RW-1:0] rad_next;
            logic [RW+1:0]   rem_next;
            logic [RW-1:0]   root_next;

            // previous stage or pipeline input
            if (i == 0)
            begin : g_first
                assign rad_p  = rad;
                assign rem_p  = '0;
                assign root_p = '0;
            end
            else
            begin : g_rest
                assign rad_p  = rad_reg[i-1];
                assign rem_p  = rem_reg[i-1];
                assign root_p = root_reg[i-1];
            end

            // bring down two radicand bits and try root*4+1
            always_comb
            begin
                rem_sh    = {rem_p, rad_p[2*RW-1 -: 2]};
                trial     = {2'b00, root_p, 2'b01};
                ge        = (rem_sh >= trial);
                rem_next  = ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
                root_next = {root_p[RW-2:0], ge};
                rad_next  = {rad_p[2*RW-3:0], 2'b00};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[i]  <= rad_next;
                    rem_reg[i]  <= rem_next;
                    root_reg[i] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[RW-1];

endmodule

// ----- src/bsc_ratio_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_ratio_div
// Pipelined restoring divider for num*2^16/den with num <= den.
// ----------------------------------------------------------------------------
module bsc_ratio_div #(
    parameter int LW = 15
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [LW-1:0]                num,
    input  logic [LW:0]                  den,
    output logic [bsc_pkg::RATIO_W-1:0]  quo
);

    localparam int SW = LW + 1;
    localparam int QW = bsc_pkg::RATIO_W;

    logic [SW-1:0] rem_reg [QW];
    logic [SW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_step
            logic [SW-1:0] rem_p;
            logic [SW-1:0] den_p;
            logic [QW-1:0] quo_p;
            logic [SW:0]   rem_sh;
            logic          ge;
            logic [SW-1:0] rem_next;

            // first stage takes the integer bit, the rest one fraction bit each
            if (i == 0)
            begin : g_first
                assign rem_p  = {1'b0, num};
                assign den_p  = den;
                assign quo_p  = '0;
                assign rem_sh = {1'b0, rem_p};
            end
            else
            begin : g_rest
                assign rem_p  = rem_reg[i-1];
                assign den_p  = den_reg[i-1];
                assign quo_p  = quo_reg[i-1];
                assign rem_sh = {rem_p, 1'b0};
            end

            // compare and subtract
            always_comb
            begin
                ge       = (rem_sh >= {1'b0, den_p});
                rem_next = ge ? SW'(rem_sh - {1'b0, den_p}) : SW'(rem_sh);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= den_p;
                    quo_reg[i] <= {quo_p[QW-2:0], ge};
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QW-1];

endmodule

// ----- src/bezier_smoothing_control_points_top.sv -----
`timescale 1ns / 1ps
// coordinate format: unsigned Q10.4 at the default parameters
// throughput: one request per cycle while no result is held, set by the fully
//   pipelined square root and ratio divider (one root or quotient bit per stage)
// a held result freezes the whole pipeline, input included, even with empty stages
// reset: valid bits cleared, smoothness back to 0.75 (49152), no clearing pass
// ----------------------------------------------------------------------------
// bezier_smoothing_control_points_top
// Cubic bezier control points for segment p1..p2 from points p0..p3.
// ----------------------------------------------------------------------------
module bezier_smoothing_control_points_top #(
    parameter int COORD_FRAC_BITS = bsc_pkg::COORD_FRAC_BITS_DEF,
    parameter int COORD_INT_BITS  = bsc_pkg::COORD_INT_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration
    input  logic                                    smoothness_wr_en,
    input  logic [bsc_pkg::SMOOTH_W-1:0]            smoothness_wr_data,
    // input channel
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] p0_x,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] p0_y,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] p1_x,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] p1_y,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] p2_x,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] p2_y,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] p3_x,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] p3_y,
    // output channel
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [bsc_pkg::OUT_W-1:0]        ctrl1_x,
    output logic signed [bsc_pkg::OUT_W-1:0]        ctrl1_y,
    output logic signed [bsc_pkg::OUT_W-1:0]        ctrl2_x,
    output logic signed [bsc_pkg::OUT_W-1:0]        ctrl2_y,
    output logic                                    degenerate,
    output logic                                    saturated
);

    localparam int CW   = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int LW   = CW + 1;                   // edge length width
    localparam int KW   = bsc_pkg::RATIO_W;
    localparam int SMW  = bsc_pkg::SMOOTH_W;
    localparam int AW   = CW + KW;                  // first product
    localparam int PW   = AW + SMW;                 // second product
    localparam int RNW  = PW - bsc_pkg::OFFSET_SHIFT + 1;
    localparam int VW   = (CW + 3 > 17) ? CW + 3 : 17;
    localparam int NST  = LW + 24;                  // pipeline depth
    localparam int SBD  = LW + KW + 1;              // sideband delay after squares
    localparam int V_DIV_END = LW + 19;
    localparam logic [PW:0] RND_HALF = (PW+1)'(1) << (bsc_pkg::OFFSET_SHIFT - 1);

    typedef struct packed {
        logic [CW-1:0]  p1x;
        logic [CW-1:0]  p1y;
        logic [CW-1:0]  p2x;
        logic [CW-1:0]  p2y;
        logic [CW-1:0]  dmx;    // |p2-p0|
        logic [CW-1:0]  dmy;
        logic [CW-1:0]  emx;    // |p3-p1|
        logic [CW-1:0]  emy;
        logic           dnx;
        logic           dny;
        logic           enx;
        logic           eny;
        logic [SMW-1:0] s;
    } side_t;

    // ------------------------------------------------------------------
    // pipeline control
    logic           en;
    logic [NST-1:0] vld_reg;

    assign en       = !(vld_reg[NST-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // smoothness register
    logic [SMW-1:0] smooth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smooth_reg <= bsc_pkg::SMOOTH_RESET;
        else if (smoothness_wr_en)
            smooth_reg <= smoothness_wr_data;
    end

    // ------------------------------------------------------------------
    // stage 1: coordinate differences and magnitudes
    function automatic logic [CW:0] sdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        sdiff = {1'b0, b} - {1'b0, a};
    endfunction

    function automatic logic [CW-1:0] smag(input logic [CW:0] d);
        logic [CW:0] n;
        n    = -d;
        smag = d[CW] ? n[CW-1:0] : d[CW-1:0];
    endfunction

    logic [CW:0]   d01x, d01y, d12x, d12y, d23x, d23y, ddx, ddy, dex, dey;
    side_t         side1_next;
    side_t         side1_reg;
    logic [CW-1:0] m_reg [6];

    always_comb
    begin
        d01x = sdiff(p0_x, p1_x);
        d01y = sdiff(p0_y, p1_y);
        d12x = sdiff(p1_x, p2_x);
        d12y = sdiff(p1_y, p2_y);
        d23x = sdiff(p2_x, p3_x);
        d23y = sdiff(p2_y, p3_y);
        ddx  = sdiff(p0_x, p2_x);
        ddy  = sdiff(p0_y, p2_y);
        dex  = sdiff(p1_x, p3_x);
        dey  = sdiff(p1_y, p3_y);
        side1_next.p1x = p1_x;
        side1_next.p1y = p1_y;
        side1_next.p2x = p2_x;
        side1_next.p2y = p2_y;
        side1_next.dmx = smag(ddx);
        side1_next.dmy = smag(ddy);
        side1_next.emx = smag(dex);
        side1_next.emy = smag(dey);
        side1_next.dnx = ddx[CW];
        side1_next.dny = ddy[CW];
        side1_next.enx = dex[CW];
        side1_next.eny = dey[CW];
        side1_next.s   = smooth_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            m_reg[0]  <= smag(d01x);
            m_reg[1]  <= smag(d01y);
            m_reg[2]  <= smag(d12x);
            m_reg[3]  <= smag(d12y);
            m_reg[4]  <= smag(d23x);
            m_reg[5]  <= smag(d23y);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: squared edge lengths
    logic [2*LW-1:0] rad_reg [3];
    side_t           side2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg <= side1_reg;
            for (int k = 0; k < 3; k++)
                rad_reg[k] <= (2*LW)'(m_reg[2*k]) * (2*LW)'(m_reg[2*k])
                            + (2*LW)'(m_reg[2*k+1]) * (2*LW)'(m_reg[2*k+1]);
        end
    end

    // ------------------------------------------------------------------
    // square root stages, sideband delay line alongside
    logic [LW-1:0] len [3];
    side_t         side_dly_reg [SBD];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_len
            bsc_isqrt #(.RW(LW)) u_isqrt (
                .clk  (clk),
                .en   (en),
                .rad  (rad_reg[g]),
                .root (len[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly_reg[0] <= side2_reg;
            for (int k = 1; k < SBD; k++)
                side_dly_reg[k] <= side_dly_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // length sums and zero detection
    logic [LW-1:0] num1_reg, num2_reg;
    logic [LW:0]   den1_reg, den2_reg;
    logic [LW:0]   sum1, sum2;
    logic [1:0]    zero_reg;
    logic [1:0]    zero_dly_reg [KW];

    always_comb
    begin
        sum1 = {1'b0, len[0]} + {1'b0, len[1]};
        sum2 = {1'b0, len[1]} + {1'b0, len[2]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg <= len[0];
            num2_reg <= len[1];
            den1_reg <= sum1;
            den2_reg <= sum2;
            zero_reg <= {(sum2 == '0), (sum1 == '0)};
            zero_dly_reg[0] <= zero_reg;
            for (int k = 1; k < KW; k++)
                zero_dly_reg[k] <= zero_dly_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // ratio dividers
    logic [KW-1:0] q1, q2;

    bsc_ratio_div #(.LW(LW)) u_div1 (
        .clk (clk),
        .en  (en),
        .num (num1_reg),
        .den (den1_reg),
        .quo (q1)
    );

    bsc_ratio_div #(.LW(LW)) u_div2 (
        .clk (clk),
        .en  (en),
        .num (num2_reg),
        .den (den2_reg),
        .quo (q2)
    );

    // ------------------------------------------------------------------
    // first product: |d| * (1 - k1), |e| * k2
    side_t         sd;
    logic [1:0]    zd;
    logic [KW-1:0] w1, w2;
    logic [AW-1:0] pa_reg [4];
    logic [3:0]    neg_a_reg, neg_b_reg;
    logic [SMW-1:0] s_a_reg;
    logic [CW-1:0] p1x_a_reg, p1y_a_reg, p2x_a_reg, p2y_a_reg;
    logic [CW-1:0] p1x_b_reg, p1y_b_reg, p2x_b_reg, p2y_b_reg;
    logic          dg_a_reg, dg_b_reg, dg_c_reg;

    always_comb
    begin
        sd = side_dly_reg[SBD-1];
        zd = zero_dly_reg[KW-1];
        w1 = bsc_pkg::Q16_ONE - (zd[0] ? KW'(0) : q1);
        w2 = zd[1] ? KW'(0) : q2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg[0] <= AW'(sd.dmx) * AW'(w1);
            pa_reg[1] <= AW'(sd.dmy) * AW'(w1);
            pa_reg[2] <= AW'(sd.emx) * AW'(w2);
            pa_reg[3] <= AW'(sd.emy) * AW'(w2);
            neg_a_reg <= {sd.eny, sd.enx, sd.dny, sd.dnx};
            s_a_reg   <= sd.s;
            p1x_a_reg <= sd.p1x;
            p1y_a_reg <= sd.p1y;
            p2x_a_reg <= sd.p2x;
            p2y_a_reg <= sd.p2y;
            dg_a_reg  <= zd[0] | zd[1];
        end
    end

    // ------------------------------------------------------------------
    // second product: times smoothness
    logic [PW-1:0] pb_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                pb_reg[k] <= PW'(pa_reg[k]) * PW'(s_a_reg);
            neg_b_reg <= neg_a_reg;
            p1x_b_reg <= p1x_a_reg;
            p1y_b_reg <= p1y_a_reg;
            p2x_b_reg <= p2x_a_reg;
            p2y_b_reg <= p2y_a_reg;
            dg_b_reg  <= dg_a_reg;
        end
    end

    // ------------------------------------------------------------------
    // round half away from zero, apply sign, form control points
    logic [PW:0]        rsum [4];
    logic signed [CW+1:0] off_next [4];
    logic signed [VW-1:0] c_reg [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rsum[k]     = {1'b0, pb_reg[k]} + RND_HALF;
            off_next[k] = neg_b_reg[k] ? -$signed({1'b0, rsum[k][PW -: RNW]})
                                       :  $signed({1'b0, rsum[k][PW -: RNW]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0] <= VW'($signed({1'b0, p1x_b_reg})) + VW'(off_next[0]);
            c_reg[1] <= VW'($signed({1'b0, p1y_b_reg})) + VW'(off_next[1]);
            c_reg[2] <= VW'($signed({1'b0, p2x_b_reg})) - VW'(off_next[2]);
            c_reg[3] <= VW'($signed({1'b0, p2y_b_reg})) - VW'(off_next[3]);
            dg_c_reg <= dg_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // saturate into the output register
    logic [bsc_pkg::OUT_W-1:0] cl_next [4];
    logic [3:0]                sat_next;
    logic [bsc_pkg::OUT_W-1:0] out_reg [4];
    logic                      dg_out_reg;
    logic                      sat_out_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (c_reg[k] > VW'(bsc_pkg::OUT_MAX))
            begin
                cl_next[k]  = bsc_pkg::OUT_POS;
                sat_next[k] = 1'b1;
            end
            else if (c_reg[k] < VW'(bsc_pkg::OUT_MIN))
            begin
                cl_next[k]  = bsc_pkg::OUT_NEG;
                sat_next[k] = 1'b1;
            end
            else
            begin
                cl_next[k]  = c_reg[k][bsc_pkg::OUT_W-1:0];
                sat_next[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                out_reg[k] <= cl_next[k];
            dg_out_reg  <= dg_c_reg;
            sat_out_reg <= |sat_next;
        end
    end

    assign out_valid  = vld_reg[NST-1];
    assign ctrl1_x    = $signed(out_reg[0]);
    assign ctrl1_y    = $signed(out_reg[1]);
    assign ctrl2_x    = $signed(out_reg[2]);
    assign ctrl2_y    = $signed(out_reg[3]);
    assign degenerate = dg_out_reg;
    assign saturated  = sat_out_reg;

    // ------------------------------------------------------------------
    // assertions

    // a held result freezes the output register
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(ctrl1_x) && $stable(ctrl2_y)
                                   && $stable(saturated))
        else $error("result changed while held");

    // the first ratio never exceeds one when its length sum is nonzero
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[V_DIV_END] && !zd[0] |-> q1 <= bsc_pkg::Q16_ONE)
        else $error("length ratio above one");

    // a zero length sum only comes from zero lengths
    a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LW+2] && zero_reg[0] |-> num1_reg == '0)
        else $error("zero sum with nonzero length");

    // the saturation flag means at least one coordinate sits at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (ctrl1_x == bsc_pkg::OUT_POS || ctrl1_x == bsc_pkg::OUT_NEG ||
             ctrl1_y == bsc_pkg::OUT_POS || ctrl1_y == bsc_pkg::OUT_NEG ||
             ctrl2_x == bsc_pkg::OUT_POS || ctrl2_x == bsc_pkg::OUT_NEG ||
             ctrl2_y == bsc_pkg::OUT_POS || ctrl2_y == bsc_pkg::OUT_NEG))
        else $error("saturation flag without clamped coordinate");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the bezier control point pipeline against a behavioral predictor:
// directed corner quadruples, then random point requests under several
// smoothness settings, with random idling on both channels and one long
// output hold-off that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW      = bsc_pkg::COORD_INT_BITS_DEF + bsc_pkg::COORD_FRAC_BITS_DEF;
    localparam int LATENCY = CW + 25;
    localparam int LIMIT   = 400000;
    localparam logic [CW-1:0] CMAX = '1;

    typedef logic [CW-1:0] coord_t;
    typedef struct packed {
        coord_t x0, y0, x1, y1, x2, y2, x3, y3;
    } quad_t;
    typedef struct packed {
        logic signed [bsc_pkg::OUT_W-1:0] c1x, c1y, c2x, c2y;
        logic degen, sat;
    } ctrl_t;

    logic clk = 0;
    logic rst_n = 0;
    logic smoothness_wr_en = 0;
    logic [bsc_pkg::SMOOTH_W-1:0] smoothness_wr_data = '0;
    logic in_valid = 0;
    logic in_stall;
    coord_t p0_x = 0, p0_y = 0, p1_x = 0, p1_y = 0;
    coord_t p2_x = 0, p2_y = 0, p3_x = 0, p3_y = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [bsc_pkg::OUT_W-1:0] ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y;
    logic degenerate, saturated;

    bezier_smoothing_control_points_top u_top (
        .clk(clk), .rst_n(rst_n),
        .smoothness_wr_en(smoothness_wr_en), .smoothness_wr_data(smoothness_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
        .p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .ctrl1_x(ctrl1_x), .ctrl1_y(ctrl1_y), .ctrl2_x(ctrl2_x), .ctrl2_y(ctrl2_y),
        .degenerate(degenerate), .saturated(saturated)
    );

    quad_t  pending_quads[$];
    ctrl_t  expected_ctrl[$];
    logic [15:0] smooth_q16 = bsc_pkg::SMOOTH_RESET;
    bit     idle_off = 0;
    bit     hold_req = 0;
    int     errors = 0;
    int     n_req = 0, n_res = 0, n_degen = 0, n_sat = 0;
    longint cycles = 0;

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
                r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic longint unsigned edge_length(coord_t ax, coord_t ay,
                                                    coord_t bx, coord_t by);
        longint dx, dy;
        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return root_floor(dx * dx + dy * dy);
    endfunction

    // d * w * s / 2^33, magnitude rounded half away from zero
    function automatic longint pull_offset(longint d, longint unsigned w,
                                           longint unsigned s);
        longint unsigned m, r;
        m = d < 0 ? -d : d;
        r = (m * w * s + (64'd1 << 32)) >> bsc_pkg::OFFSET_SHIFT;
        return d < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [15:0] clamp16(longint v, inout logic sat);
        if (v > bsc_pkg::OUT_MAX)
        begin
            sat = 1'b1;
            return bsc_pkg::OUT_POS;
        end
        if (v < bsc_pkg::OUT_MIN)
        begin
            sat = 1'b1;
            return bsc_pkg::OUT_NEG;
        end
        return v[15:0];
    endfunction

    function automatic ctrl_t predict_ctrl(quad_t q, logic [15:0] s);
        ctrl_t c;
        longint unsigned l1, l2, l3, k1, k2;
        logic sat;
        l1 = edge_length(q.x0, q.y0, q.x1, q.y1);
        l2 = edge_length(q.x1, q.y1, q.x2, q.y2);
        l3 = edge_length(q.x2, q.y2, q.x3, q.y3);
        c.degen = 1'b0;
        sat = 1'b0;
        k1 = 0;
        k2 = 0;
        if (l1 + l2 != 0) k1 = (l1 * 65536) / (l1 + l2); else c.degen = 1'b1;
        if (l2 + l3 != 0) k2 = (l2 * 65536) / (l2 + l3); else c.degen = 1'b1;
        c.c1x = clamp16(longint'(q.x1) + pull_offset(longint'(q.x2) - longint'(q.x0),
                        65536 - k1, s), sat);
        c.c1y = clamp16(longint'(q.y1) + pull_offset(longint'(q.y2) - longint'(q.y0),
                        65536 - k1, s), sat);
        c.c2x = clamp16(longint'(q.x2) - pull_offset(longint'(q.x3) - longint'(q.x1),
                        k2, s), sat);
        c.c2y = clamp16(longint'(q.y2) - pull_offset(longint'(q.y3) - longint'(q.y1),
                        k2, s), sat);
        c.sat = sat;
        return c;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CMAX;
            2: return coord_t'($urandom_range(0, 15));
            3: return CMAX - coord_t'($urandom_range(0, 15));
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic quad_t rand_quad();
        quad_t q;
        q = quad_t'({$urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(0, 7))
            0:
            begin
                q.x1 = q.x0; q.y1 = q.y0; q.x2 = q.x0; q.y2 = q.y0;
            end
            1:
            begin
                q.x2 = q.x1; q.y2 = q.y1; q.x3 = q.x1; q.y3 = q.y1;
            end
            2:
            begin
                q.x0 = rand_coord(); q.y0 = rand_coord(); q.x1 = rand_coord();
                q.y1 = rand_coord(); q.x2 = rand_coord(); q.y2 = rand_coord();
                q.x3 = rand_coord(); q.y3 = rand_coord();
            end
            3:
            begin
                // short segments near one point
                q.x1 = q.x0 + coord_t'($urandom_range(0, 40));
                q.y1 = q.y0 + coord_t'($urandom_range(0, 40));
                q.x2 = q.x1 + coord_t'($urandom_range(0, 40));
                q.y2 = q.y1 + coord_t'($urandom_range(0, 40));
                q.x3 = q.x2 + coord_t'($urandom_range(0, 40));
                q.y3 = q.y2 + coord_t'($urandom_range(0, 40));
            end
            default: ;
        endcase
        return q;
    endfunction

    task automatic write_smoothness(logic [15:0] v);
        @(negedge clk);
        smoothness_wr_en   <= 1'b1;
        smoothness_wr_data <= v;
        @(negedge clk);
        smoothness_wr_en <= 1'b0;
        smooth_q16 = v;
    endtask

    task automatic drain_pipeline();
        while (pending_quads.size() != 0 || in_valid || expected_ctrl.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    // input acceptance, sampled at the rising edge
    logic accepted_in = 0;
    always @(posedge clk)
    begin
        accepted_in = in_valid && !in_stall;
        if (accepted_in)
        begin
            expected_ctrl.push_back(predict_ctrl(
                {p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y}, smooth_q16));
            n_req++;
        end
    end

    // request driver
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || accepted_in)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_quads.size() != 0)
                begin
                    quad_t q;
                    q = pending_quads.pop_front();
                    {p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y} <= q;
                    in_valid <= 1'b1;
                    if (!idle_off && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 18);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            ctrl_t e;
            if (expected_ctrl.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_ctrl.pop_front();
                n_res++;
                n_degen += degenerate;
                n_sat += saturated;
                if (ctrl1_x !== e.c1x)
                begin
                    $error("ctrl1_x expected %0d got %0d", e.c1x, ctrl1_x); errors++;
                end
                if (ctrl1_y !== e.c1y)
                begin
                    $error("ctrl1_y expected %0d got %0d", e.c1y, ctrl1_y); errors++;
                end
                if (ctrl2_x !== e.c2x)
                begin
                    $error("ctrl2_x expected %0d got %0d", e.c2x, ctrl2_x); errors++;
                end
                if (ctrl2_y !== e.c2y)
                begin
                    $error("ctrl2_y expected %0d got %0d", e.c2y, ctrl2_y); errors++;
                end
                if (degenerate !== e.degen)
                begin
                    $error("degenerate expected %0b got %0b", e.degen, degenerate);
                    errors++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated expected %0b got %0b", e.sat, saturated);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall, random bursts plus a long hold-off on request
    int stall_left = 0;
    int hold_left = 0;
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = 300;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!idle_off && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(0, 17);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // stimulus
    initial
    begin
        logic [15:0] settings[5];
        settings = '{16'd3277, 16'd62259, 16'hffff, 16'd0, 16'h8001};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corners at reset smoothness
        pending_quads.push_back('0);
        pending_quads.push_back('1);
        pending_quads.push_back({CMAX, CMAX, 14'd0, 14'd0, CMAX, CMAX, 14'd0, 14'd0});
        pending_quads.push_back({14'd0, 14'd0, CMAX, CMAX, 14'd0, 14'd0, CMAX, CMAX});
        pending_quads.push_back({14'd0, 14'd0, 14'd0, 14'd0, CMAX, CMAX, CMAX, CMAX});
        pending_quads.push_back({CMAX, 14'd0, 14'd5, 14'd5, 14'd5, 14'd5, 14'd0, CMAX});
        pending_quads.push_back({14'd0, CMAX, CMAX, 14'd0, 14'd0, CMAX, CMAX, 14'd0});
        pending_quads.push_back({14'd100, 14'd100, 14'd100, 14'd100,
                                 14'd900, 14'd200, 14'd900, 14'd200});
        pending_quads.push_back({14'h2aaa, 14'h1555, 14'h1555, 14'h2aaa,
                                 14'h2aaa, 14'h1555, 14'h1555, 14'h2aaa});
        drain_pipeline();

        // several smoothness settings: min, max, full scale, zero and mid
        foreach (settings[i])
        begin
            write_smoothness(settings[i]);
            pending_quads.push_back('1);
            pending_quads.push_back({CMAX, CMAX, 14'd0, 14'd0, CMAX, CMAX, 14'd0, 14'd0});
            repeat (140) pending_quads.push_back(rand_quad());
            if (i == 1)
            begin
                hold_req = 1;
                repeat (120) pending_quads.push_back(rand_quad());
            end
            drain_pipeline();
        end

        // random smoothness, no idling at the end
        write_smoothness(16'($urandom_range(3277, 62259)));
        idle_off = 1;
        repeat (150) pending_quads.push_back(rand_quad());
        drain_pipeline();

        $display("%0d requests, %0d results (%0d degenerate, %0d saturated)",
                 n_req, n_res, n_degen, n_sat);
        $display("smoothness swept over min, max, full scale, zero and mid values");
        if (errors == 0 && expected_ctrl.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
